FILE: rtl/hrsp_pkg.sv
// Package for the HTTP request stream parser: codes, state types and match tables.
`timescale 1ns / 1ps
package hrsp_pkg;

  // Default width of the length and body counters
  localparam int unsigned LENGTH_BITS_DEFAULT = 32;
  // Width of the content_length result field
  localparam int unsigned CL_W = 32;

  typedef logic [7:0] char_t;

  localparam char_t CH_CR    = 8'h0D;
  localparam char_t CH_LF    = 8'h0A;
  localparam char_t CH_SP    = 8'h20;
  localparam char_t CH_TAB   = 8'h09;
  localparam char_t CH_COLON = 8'h3A;
  localparam char_t CASE_BIT = 8'h20;

  // Parser phases
  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_URI       = 4'd1,
    PH_VERSION   = 4'd2,
    PH_REQ_LF    = 4'd3,
    PH_KEY_START = 4'd4,
    PH_KEY       = 4'd5,
    PH_SKIP      = 4'd6,
    PH_VALUE     = 4'd7,
    PH_TRAIL     = 4'd8,
    PH_HDR_LF    = 4'd9,
    PH_END_LF    = 4'd10,
    PH_BODY      = 4'd11,
    PH_DONE      = 4'd12,
    PH_ERROR     = 4'd13
  } phase_t;

  typedef enum logic [2:0] {
    KIND_SYNTAX  = 3'd0,
    KIND_URI     = 3'd1,
    KIND_KEY     = 3'd2,
    KIND_VALUE   = 3'd3,
    KIND_BODY    = 3'd4,
    KIND_IGNORED = 3'd5
  } kind_t;

  typedef enum logic [2:0] {
    METHOD_UNKNOWN = 3'd0,
    METHOD_GET     = 3'd1,
    METHOD_POST    = 3'd2,
    METHOD_PUT     = 3'd3,
    METHOD_DELETE  = 3'd4,
    METHOD_HEAD    = 3'd5,
    METHOD_OPTIONS = 3'd6
  } method_t;

  typedef enum logic [1:0] {
    VERSION_UNKNOWN = 2'd0,
    VERSION_1_0     = 2'd1,
    VERSION_1_1     = 2'd2
  } version_t;

  typedef enum logic [1:0] {
    STATUS_BUSY  = 2'd0,
    STATUS_DONE  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_t;

  localparam int unsigned N_METHODS  = 6;
  localparam int unsigned N_VERSIONS = 2;
  localparam int unsigned KEY_LEN    = 14;
  localparam logic [3:0]  VERSION_LEN = 4'd8;

  // Method names, left aligned, padded with zero
  localparam char_t METHOD_CHARS [N_METHODS][7] = '{
    '{"G", "E", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"P", "O", "S", "T", 8'h00, 8'h00, 8'h00},
    '{"P", "U", "T", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"D", "E", "L", "E", "T", "E", 8'h00},
    '{"H", "E", "A", "D", 8'h00, 8'h00, 8'h00},
    '{"O", "P", "T", "I", "O", "N", "S"}
  };
  localparam logic [3:0] METHOD_LENS [N_METHODS] = '{4'd3, 4'd4, 4'd3, 4'd6, 4'd4, 4'd7};
  localparam method_t METHOD_IDS [N_METHODS] = '{
    METHOD_GET, METHOD_POST, METHOD_PUT, METHOD_DELETE, METHOD_HEAD, METHOD_OPTIONS
  };

  localparam char_t VERSION_CHARS [N_VERSIONS][8] = '{
    '{"H", "T", "T", "P", "/", "1", ".", "0"},
    '{"H", "T", "T", "P", "/", "1", ".", "1"}
  };
  localparam version_t VERSION_IDS [N_VERSIONS] = '{VERSION_1_0, VERSION_1_1};

  localparam char_t KEY_CHARS [KEY_LEN] = '{
    "c", "o", "n", "t", "e", "n", "t", "-", "l", "e", "n", "g", "t", "h"
  };

  // Narrow parser state; the counters live beside it in the core
  typedef struct packed {
    phase_t     phase;
    logic [5:0] method_cand;
    logic [3:0] match_pos;
    method_t    method_found;
    logic [1:0] version_cand;
    version_t   version_found;
    logic       uri_seen;
    logic       key_match;
    logic       length_seen;
    logic       digit_seen;
  } ctl_state_t;

  localparam ctl_state_t CTL_RESET = '{
    phase:         PH_METHOD,
    method_cand:   6'h3F,
    match_pos:     4'd0,
    method_found:  METHOD_UNKNOWN,
    version_cand:  2'h3,
    version_found: VERSION_UNKNOWN,
    uri_seen:      1'b0,
    key_match:     1'b1,
    length_seen:   1'b0,
    digit_seen:    1'b0
  };

  // One result item
  typedef struct packed {
    char_t            out_byte;
    kind_t            kind;
    logic             field_end;
    method_t          method_code;
    version_t         version_code;
    status_t          status;
    logic [CL_W-1:0]  content_length;
    logic             length_present;
    logic             call_done;
  } result_t;

  // Saturating match position increment
  function automatic logic [3:0] bump(input logic [3:0] p);
    bump = (p == 4'hF) ? p : p + 4'd1;
  endfunction

endpackage

FILE: rtl/hrsp_length.sv
// Decimal accumulator for the content-length value: value*10 + digit with overflow flag.
`timescale 1ns / 1ps
module hrsp_length #(
  parameter int unsigned LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic [LENGTH_BITS-1:0] value,
  input  logic [3:0]             digit,
  output logic [LENGTH_BITS-1:0] value_next,
  output logic                   overflow
);
  import hrsp_pkg::*;

  logic [LENGTH_BITS+3:0] wide;
  logic [LENGTH_BITS+3:0] value_ext;

  // times ten as 8x + 2x, four guard bits catch overflow
  assign value_ext  = {4'b0000, value};
  assign wide       = (value_ext << 3) + (value_ext << 1) + {{LENGTH_BITS{1'b0}}, digit};
  assign value_next = wide[LENGTH_BITS-1:0];
  assign overflow   = |wide[LENGTH_BITS+3:LENGTH_BITS];

endmodule

FILE: rtl/hrsp_core.sv
// Parser state registers and the per-byte next-state and result logic.
`timescale 1ns / 1ps
module hrsp_core #(
  parameter int unsigned LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic [7:0]        in_byte,
  input  logic              restart,
  input  logic              end_of_buffer,
  output hrsp_pkg::result_t result
);
  import hrsp_pkg::*;

  ctl_state_t             ctl, ctl_next, cur;
  logic [LENGTH_BITS-1:0] length_value, length_value_next, cur_len;
  logic [LENGTH_BITS-1:0] body_left, body_left_next, cur_body, body_dec;
  logic [LENGTH_BITS-1:0] len_acc;
  logic                   len_ovf;

  // digit accumulate for the length value
  hrsp_length #(.LENGTH_BITS(LENGTH_BITS)) u_length (
    .value      (cur_len),
    .digit      (in_byte[3:0]),
    .value_next (len_acc),
    .overflow   (len_ovf)
  );

  // state registers, updated once per processed item
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl          <= CTL_RESET;
      length_value <= '0;
      body_left    <= '0;
    end else if (advance) begin
      ctl          <= ctl_next;
      length_value <= length_value_next;
      body_left    <= body_left_next;
    end
  end

  // restart takes effect before the byte
  assign cur      = restart ? CTL_RESET : ctl;
  assign cur_len  = restart ? '0 : length_value;
  assign cur_body = restart ? '0 : body_left;
  assign body_dec = (cur_body != '0) ? cur_body - 1'b1 : cur_body;

  // per-byte step
  always_comb begin
    char_t      c;
    char_t      ob;
    kind_t      kind;
    logic       fend;
    logic [3:0] pos;
    logic       is_digit;
    logic       is_blank;
    logic       key_ok;
    method_t    m_found;
    version_t   v_found;
    status_t    st;

    c        = in_byte;
    ob       = in_byte;
    kind     = KIND_SYNTAX;
    fend     = 1'b0;
    pos      = cur.match_pos;
    is_digit = c inside {[8'h30:8'h39]};
    is_blank = c inside {CH_SP, CH_TAB};
    key_ok   = 1'b0;
    m_found  = METHOD_UNKNOWN;
    v_found  = VERSION_UNKNOWN;

    ctl_next          = cur;
    length_value_next = cur_len;
    body_left_next    = cur_body;

    case (cur.phase)
      PH_METHOD: begin
        if (c == CH_SP) begin
          for (int i = 0; i < N_METHODS; i++) begin
            if (cur.method_cand[i] && METHOD_LENS[i] == cur.match_pos) begin
              m_found = METHOD_IDS[i];
            end
          end
          if (m_found != METHOD_UNKNOWN) begin
            ctl_next.method_found = m_found;
            ctl_next.phase        = PH_URI;
          end else begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end else begin
          for (int i = 0; i < N_METHODS; i++) begin
            if (!(cur.match_pos < METHOD_LENS[i] &&
                  METHOD_CHARS[i][cur.match_pos[2:0]] == c)) begin
              ctl_next.method_cand[i] = 1'b0;
            end
          end
          ctl_next.match_pos = bump(cur.match_pos);
          if (ctl_next.method_cand == '0) begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end
      end
      PH_URI: begin
        if (c == CH_SP && cur.uri_seen) begin
          ctl_next.phase     = PH_VERSION;
          ctl_next.match_pos = 4'd0;
        end else if (c == CH_SP || c == CH_CR) begin
          ctl_next.phase = PH_ERROR;
          kind           = KIND_IGNORED;
        end else begin
          ctl_next.uri_seen = 1'b1;
          kind              = KIND_URI;
        end
      end
      PH_VERSION: begin
        if (c == CH_CR) begin
          if (cur.match_pos == VERSION_LEN) begin
            for (int i = 0; i < N_VERSIONS; i++) begin
              if (cur.version_cand[i]) begin
                v_found = VERSION_IDS[i];
              end
            end
          end
          if (v_found != VERSION_UNKNOWN) begin
            ctl_next.version_found = v_found;
            ctl_next.phase         = PH_REQ_LF;
          end else begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end else begin
          for (int i = 0; i < N_VERSIONS; i++) begin
            if (!(cur.match_pos < VERSION_LEN &&
                  VERSION_CHARS[i][cur.match_pos[2:0]] == c)) begin
              ctl_next.version_cand[i] = 1'b0;
            end
          end
          ctl_next.match_pos = bump(cur.match_pos);
          if (ctl_next.version_cand == '0) begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end
      end
      PH_REQ_LF, PH_HDR_LF: begin
        if (c == CH_LF) begin
          fend           = 1'b1;
          ctl_next.phase = PH_KEY_START;
        end else begin
          ctl_next.phase = PH_ERROR;
          kind           = KIND_IGNORED;
        end
      end
      PH_KEY_START, PH_KEY: begin
        if (c == CH_CR) begin
          if (cur.phase == PH_KEY_START) begin
            ctl_next.phase = PH_END_LF;
          end else begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end else if (c == CH_COLON) begin
          // only a full "content-length" key keeps the match
          if (cur.phase == PH_KEY_START || cur.match_pos != 4'(KEY_LEN)) begin
            ctl_next.key_match = 1'b0;
          end
          if (ctl_next.key_match) begin
            length_value_next = '0;
          end
          ctl_next.digit_seen = 1'b0;
          ctl_next.phase      = PH_SKIP;
        end else begin
          if (cur.phase == PH_KEY_START) begin
            pos                = 4'd0;
            ctl_next.key_match = 1'b1;
          end
          if (c inside {[8'h41:8'h5A]}) begin
            ob = c + CASE_BIT;
          end
          key_ok = (pos < 4'(KEY_LEN)) ? (KEY_CHARS[pos] == ob) : 1'b0;
          if (!key_ok) begin
            ctl_next.key_match = 1'b0;
          end
          ctl_next.match_pos = bump(pos);
          ctl_next.phase     = PH_KEY;
          kind               = KIND_KEY;
        end
      end
      PH_SKIP, PH_VALUE: begin
        if (cur.phase == PH_SKIP && is_blank) begin
          kind = KIND_SYNTAX;
        end else begin
          ctl_next.phase = PH_VALUE;
          if (!cur.key_match) begin
            // value of some other header passes through
            if (c == CH_CR) begin
              ctl_next.phase = PH_HDR_LF;
              kind           = KIND_SYNTAX;
            end else begin
              kind = KIND_VALUE;
            end
          end else if (is_digit) begin
            if (len_ovf) begin
              ctl_next.phase = PH_ERROR;
              kind           = KIND_IGNORED;
            end else begin
              length_value_next   = len_acc;
              ctl_next.digit_seen = 1'b1;
              kind                = KIND_VALUE;
            end
          end else if (c == CH_CR && cur.digit_seen) begin
            ctl_next.length_seen = 1'b1;
            ctl_next.phase       = PH_HDR_LF;
            kind                 = KIND_SYNTAX;
          end else if (is_blank && cur.digit_seen) begin
            ctl_next.phase = PH_TRAIL;
            kind           = KIND_VALUE;
          end else begin
            ctl_next.phase = PH_ERROR;
            kind           = KIND_IGNORED;
          end
        end
      end
      PH_TRAIL: begin
        if (is_blank) begin
          kind = KIND_VALUE;
        end else if (c == CH_CR) begin
          ctl_next.length_seen = 1'b1;
          ctl_next.phase       = PH_HDR_LF;
        end else begin
          ctl_next.phase = PH_ERROR;
          kind           = KIND_IGNORED;
        end
      end
      PH_END_LF: begin
        if (c == CH_LF) begin
          fend = 1'b1;
          if (cur.length_seen && cur_len != '0) begin
            body_left_next = cur_len;
            ctl_next.phase = PH_BODY;
          end else begin
            ctl_next.phase = PH_DONE;
          end
        end else begin
          ctl_next.phase = PH_ERROR;
          kind           = KIND_IGNORED;
        end
      end
      PH_BODY: begin
        kind           = KIND_BODY;
        body_left_next = body_dec;
        if (body_dec == '0) begin
          ctl_next.phase = PH_DONE;
        end
      end
      PH_DONE: begin
        kind = KIND_IGNORED;
      end
      default: begin
        ctl_next.phase = PH_ERROR;
        kind           = KIND_IGNORED;
      end
    endcase

    // status follows the phase after this byte
    if (ctl_next.phase == PH_DONE) begin
      st = STATUS_DONE;
    end else if (ctl_next.phase == PH_ERROR) begin
      st = STATUS_ERROR;
    end else begin
      st = STATUS_BUSY;
    end

    result.out_byte       = ob;
    result.kind           = kind;
    result.field_end      = fend;
    result.method_code    = ctl_next.method_found;
    result.version_code   = ctl_next.version_found;
    result.status         = st;
    result.content_length = CL_W'(length_value_next);
    result.length_present = ctl_next.length_seen;
    result.call_done      = end_of_buffer && (st == STATUS_DONE);
  end

endmodule

FILE: rtl/http_request_stream_parser.sv
// Top level of the HTTP request stream parser: input register, parser core, result register.
//
//   channel   signals                                           direction
//   input     in_valid, in_stall, in_byte, restart, end_of_buffer  in (in_stall out)
//   output    out_valid, out_stall, out_byte, byte_kind, ...       out (out_stall in)
//
// One byte per cycle sustained while results are not stalled; each item passes from acceptance
// through the input register, then the parser step into the result register.
// The parser step is one pass of compare logic plus the length multiply-by-ten add.
// Synchronous reset returns the parser to the method phase and empties both registers.
// A stalled result holds the result register; one more item is then held in the input
// register, after which in_stall rises.
`timescale 1ns / 1ps
module http_request_stream_parser #(
  parameter int unsigned LENGTH_BITS = hrsp_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        restart,
  input  logic        end_of_buffer,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [2:0]  byte_kind,
  output logic        field_end,
  output logic [2:0]  method_code,
  output logic [1:0]  version_code,
  output logic [1:0]  status,
  output logic [31:0] content_length,
  output logic        length_present,
  output logic        call_done
);
  import hrsp_pkg::*;

  logic       in_full;
  logic [7:0] in_byte_q;
  logic       restart_q;
  logic       eob_q;
  logic       out_free;
  logic       advance;
  logic       in_take;
  result_t    step_result;
  result_t    result_q;

  // handshake control
  assign out_free = !out_valid || !out_stall;
  assign advance  = in_full && out_free;
  assign in_stall = in_full && !out_free;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_q <= in_byte;
      restart_q <= restart;
      eob_q     <= end_of_buffer;
    end
  end

  // parser step
  hrsp_core #(.LENGTH_BITS(LENGTH_BITS)) u_core (
    .clk           (clk),
    .rst           (rst),
    .advance       (advance),
    .in_byte       (in_byte_q),
    .restart       (restart_q),
    .end_of_buffer (eob_q),
    .result        (step_result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= step_result;
    end
  end

  assign out_byte       = result_q.out_byte;
  assign byte_kind      = result_q.kind;
  assign field_end      = result_q.field_end;
  assign method_code    = result_q.method_code;
  assign version_code   = result_q.version_code;
  assign status         = result_q.status;
  assign content_length = result_q.content_length;
  assign length_present = result_q.length_present;
  assign call_done      = result_q.call_done;

  // checks
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result register can take an item");

  a_advance_fills_output: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid)
    else $error("processed item did not reach the result register");

  a_error_byte_ignored: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == STATUS_ERROR) |-> byte_kind == KIND_IGNORED)
    else $error("byte in error state not marked ignored");

  a_field_end_on_lf: assert property (@(posedge clk) disable iff (rst)
    (out_valid && field_end) |-> (out_byte == CH_LF && byte_kind == KIND_SYNTAX))
    else $error("line end flagged on a byte other than LF");

  a_call_done_complete: assert property (@(posedge clk) disable iff (rst)
    (out_valid && call_done) |-> status == STATUS_DONE)
    else $error("call done without a complete request");

endmodule
